// ----- hw/rtl/sbq_pkg.sv -----
`default_nettype none

package sbq_pkg;

	// sample and coefficient formats
	localparam int SAMPLE_WIDTH = 24;
	localparam int CHANNELS     = 2;
	localparam int COEF_WIDTH   = 32;
	localparam int FRAC_BITS    = 28;

	// full precision datapath widths: one product, then five products summed
	localparam int PROD_WIDTH = COEF_WIDTH + SAMPLE_WIDTH;
	localparam int ACC_WIDTH  = PROD_WIDTH + 3;
	localparam int RND_WIDTH  = ACC_WIDTH - FRAC_BITS;

	// register file addressing
	localparam int DATA_WIDTH      = 32;
	localparam int REG_INDEX_WIDTH = 3;
	localparam int ADDR_WIDTH      = REG_INDEX_WIDTH + 2;

	localparam logic [REG_INDEX_WIDTH-1:0] REG_B0 = 3'd0;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_B1 = 3'd1;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_B2 = 3'd2;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_A1 = 3'd3;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_A2 = 3'd4;

	// unity gain in Q4.28
	localparam logic [COEF_WIDTH-1:0] COEF_ONE  = COEF_WIDTH'(1) << FRAC_BITS;
	localparam logic [COEF_WIDTH-1:0] COEF_ZERO = '0;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [COEF_WIDTH-1:0]   coef_t;
	typedef logic signed [PROD_WIDTH-1:0]   prod_t;
	typedef logic signed [ACC_WIDTH-1:0]    acc_t;
	typedef logic signed [RND_WIDTH-1:0]    rnd_t;

	typedef struct packed {
		coef_t b0;
		coef_t b1;
		coef_t b2;
		coef_t a1;
		coef_t a2;
	} coef_set_t;

	// saturation limits
	localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	// one half lsb of the output, for round to nearest with ties upward
	localparam logic [ACC_WIDTH-1:0] ROUND_BIAS =
		{{(ACC_WIDTH-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

endpackage

`default_nettype wire

// ----- hw/rtl/sbq_apb_regs.sv -----
`default_nettype none

module sbq_apb_regs
	import sbq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [ADDR_WIDTH-1:0] paddr,
	input  wire logic [DATA_WIDTH-1:0] pwdata,
	output logic      [DATA_WIDTH-1:0] prdata,
	output logic                       pready,
	output coef_set_t                  coefs
);

	coef_set_t                  coefs_q;
	logic [REG_INDEX_WIDTH-1:0] reg_index;
	logic                       wr_en;

	assign reg_index = paddr[ADDR_WIDTH-1:2];
	assign wr_en     = psel & penable & pwrite;
	assign pready    = 1'b1;
	assign coefs     = coefs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.b0 <= COEF_ONE;
			coefs_q.b1 <= COEF_ZERO;
			coefs_q.b2 <= COEF_ZERO;
			coefs_q.a1 <= COEF_ZERO;
			coefs_q.a2 <= COEF_ZERO;
		end else if (wr_en) begin
			unique case (reg_index)
				REG_B0: coefs_q.b0 <= pwdata;
				REG_B1: coefs_q.b1 <= pwdata;
				REG_B2: coefs_q.b2 <= pwdata;
				REG_A1: coefs_q.a1 <= pwdata;
				REG_A2: coefs_q.a2 <= pwdata;
				default: ; // unmapped address, write dropped
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			REG_B0: prdata = coefs_q.b0;
			REG_B1: prdata = coefs_q.b1;
			REG_B2: prdata = coefs_q.b2;
			REG_A1: prdata = coefs_q.a1;
			REG_A2: prdata = coefs_q.a2;
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/sbq_channel.sv -----
`default_nettype none

module sbq_channel
	import sbq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      advance,
	input  wire sample_t   x_in,
	input  wire coef_set_t coefs,
	output sample_t        y_out
);

	sample_t x1_q, x2_q, y1_q, y2_q;
	prod_t   p_b0, p_b1, p_b2, p_a1, p_a2;
	acc_t    acc;
	rnd_t    rnd;
	logic    in_range;
	sample_t y;

	// five products in parallel
	assign p_b0 = PROD_WIDTH'(coefs.b0 * x_in);
	assign p_b1 = PROD_WIDTH'(coefs.b1 * x1_q);
	assign p_b2 = PROD_WIDTH'(coefs.b2 * x2_q);
	assign p_a1 = PROD_WIDTH'(coefs.a1 * y1_q);
	assign p_a2 = PROD_WIDTH'(coefs.a2 * y2_q);

	assign acc = ACC_WIDTH'(p_b0) + ACC_WIDTH'(p_b1) + ACC_WIDTH'(p_b2)
		- ACC_WIDTH'(p_a1) - ACC_WIDTH'(p_a2) + $signed(ROUND_BIAS);

	// floor after the half lsb bias
	assign rnd = $signed(acc[ACC_WIDTH-1:FRAC_BITS]);

	// fits when all bits above the sample sign agree with it
	assign in_range = (&rnd[RND_WIDTH-1:SAMPLE_WIDTH-1]) | ~(|rnd[RND_WIDTH-1:SAMPLE_WIDTH-1]);

	always_comb begin
		priority if (in_range) begin
			y = $signed(rnd[SAMPLE_WIDTH-1:0]);
		end else if (rnd[RND_WIDTH-1]) begin
			y = $signed(SAMPLE_MIN);
		end else begin
			y = $signed(SAMPLE_MAX);
		end
	end

	assign y_out = y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (advance) begin
			x1_q <= x_in;
			x2_q <= x1_q;
			y1_q <= y;
			y2_q <= y1_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_input_history: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (x1_q == $past(x_in)) && (x2_q == $past(x1_q)))
		else $error("input history did not shift with the word");

	a_output_history: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (y1_q == $past(y)) && (y2_q == $past(y1_q)))
		else $error("stored output differs from the delivered sample");

	a_history_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(x1_q) && $stable(x2_q) && $stable(y1_q) && $stable(y2_q))
		else $error("filter state moved without a word");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/stereo_biquad_peaking_eq_core.sv -----
`default_nettype none

// Stereo Direct Form I biquad for peaking equalization. Each input word is one
// frame: a signed 24-bit left and right sample plus a last-frame flag that is
// passed through untouched. Both channels use the same five Q4.28 coefficients
// (b0, b1, b2, a1, a2, already normalized by a0, a1 and a2 subtracted), written
// over the APB port at byte addresses 0x00, 0x04, 0x08, 0x0c and 0x10; after
// reset the filter is a unity pass-through. The sum of the five products is kept
// at full precision, rounded to nearest (ties toward plus infinity) and
// saturated to 24 bits; the saturated value is what the filter remembers.
// Throughput is one frame per clock while the sink keeps taking output words; each
// frame passes through an input register, then the whole filter step into the
// output register. The clock rate is set by the feedback loop through the 32x24
// multipliers, the five-term adder and the saturation logic, since the next frame
// needs the previous output in the same cycle. Coefficients must only be changed
// while no frame is in flight.

module stereo_biquad_peaking_eq_core
	import sbq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [ADDR_WIDTH-1:0] paddr,
	input  wire logic [DATA_WIDTH-1:0] pwdata,
	output logic      [DATA_WIDTH-1:0] prdata,
	output logic                       pready,
	// input frames
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire sample_t               sample_left,
	input  wire sample_t               sample_right,
	input  wire logic                  last_frame,
	// filtered frames
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output sample_t                    out_left,
	output sample_t                    out_right,
	output logic                       last_out
);

	coef_set_t coefs;

	// input register stage
	logic    valid_s1;
	sample_t x_s1 [CHANNELS];
	logic    last_s1;

	// output register
	logic    out_valid_q;
	sample_t y_q  [CHANNELS];
	logic    last_q;

	sample_t y    [CHANNELS];
	logic    in_accept;
	logic    advance;

	sbq_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coefs   (coefs)
	);

	// the staged word moves on whenever the output register is empty or draining,
	// so stage one takes a new word in the same cycle that its own word leaves
	assign advance   = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready  = ~valid_s1 | advance;
	assign in_accept = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload of stage one, no reset needed
	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_s1[0] <= sample_left;
			x_s1[1] <= sample_right;
			last_s1 <= last_frame;
		end
	end

	// one filter per channel, each with its own history
	for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
		sbq_channel u_chan (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.x_in    (x_s1[ch]),
			.coefs   (coefs),
			.y_out   (y[ch])
		);
	end

	// output register: holds the word until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			y_q    <= y;
			last_q <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_left  = y_q[0];
	assign out_right = y_q[1];
	assign last_out  = last_q;

`ifndef NO_ASSERTIONS
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled while the pipeline could move");

	a_out_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance))
		else $error("output word appeared without a staged word");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> !out_valid_q || out_ready)
		else $error("pending output word overwritten");
`endif

endmodule

`default_nettype wire
